// File: sv/tricubic_grid_interpolator_macros.svh
// assertion macros shared by the interpolator modules
`ifndef TRICUBIC_GRID_INTERPOLATOR_MACROS_SVH
`define TRICUBIC_GRID_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked by i_clk, held off during reset
`define TGI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, clocked by i_clk, held off during reset
`define TGI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TGI_ASSERT_IMP(lbl, ante, cons, msg)
`define TGI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/tgi_pkg.sv
package tgi_pkg;

    // datapath widths
    localparam int OFF_W = 8;   // window start along one axis
    localparam int U_W   = 34;  // local coordinate, signed Q18.16
    localparam int P_W   = 57;  // cubic input/output, signed Q.16
    localparam int H_W   = 61;  // cubic coefficients and partial sums

    // clip limits
    localparam logic [H_W-1:0] ACC_LIM   = {1'b0, {60{1'b1}}};
    localparam logic [P_W-1:0] STAGE_LIM = {1'b0, {56{1'b1}}};

    // configuration register indexes
    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_START_Z = 3'd2;
    localparam logic [2:0] CFG_INV_X   = 3'd3;
    localparam logic [2:0] CFG_INV_Y   = 3'd4;
    localparam logic [2:0] CFG_INV_Z   = 3'd5;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic                  opcode;
        logic [14:0]           addr;
        logic [31:0]           value;
        logic [OFF_W-1:0]      ox;
        logic [OFF_W-1:0]      oy;
        logic [OFF_W-1:0]      oz;
        logic [U_W-1:0]        ux;
        logic [U_W-1:0]        uy;
        logic [U_W-1:0]        uz;
        logic                  clip;
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [3:0][P_W-1:0]   p;
        logic [U_W-1:0]        u;
    } t_cubic_req;

    typedef struct packed {
        logic                  done;
        logic [P_W-1:0]        r;
        logic                  clip;
    } t_cubic_rsp;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_RND, F_PUSH} t_front_state;
    typedef enum logic [2:0] {C_IDLE, C_MLO, C_MHI, C_ACC, C_FIN} t_cubic_state;
    typedef enum logic [2:0] {B_IDLE, B_READ, B_GO, B_WAIT, B_FIN} t_back_state;
    typedef enum logic [1:0] {LV_Z, LV_Y, LV_X} t_level;

endpackage

// File: sv/tricubic_grid_interpolator.sv
// Tricubic Catmull-Rom interpolator over a 3D sample grid.
// Input channel (i_in_valid / o_in_stall): a word with i_opcode 0 writes
// i_sample_value into the grid at i_sample_address and gives no result;
// a word with i_opcode 1 queries the field at (i_pos_x, i_pos_y, i_pos_z),
// Q16.16, and gives one result word on the output channel
// (o_out_valid / i_out_stall) with o_field_value and o_saturated.
// Configuration: origin and reciprocal spacing per axis through the plain
// write port (i_cfg_we, i_cfg_index, i_cfg_data), written while idle.
// A front end scales the three coordinates (a multiply step and a rounding
// step per axis on one 33x32 multiplier) and queues the command; a back end
// gathers the 4x4x4 neighbourhood from a one-read-per-cycle sample memory,
// one group of four at a time, and runs 21 cubics on one shared unit.
// The back end handles one query at a time and its pace sets the sustained
// rate, while the queue lets the front end accept further words meanwhile.
// Reset clears control state and sets origin 0 and spacing 1.0; grid
// samples are not cleared and must be written before they are read.
// While the receiver stalls the result is held in the output register; the
// back end then stops at its next result and the queue fills, after which
// o_in_stall rises.
module tricubic_grid_interpolator #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [14:0] i_sample_address,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_field_value,
    output logic        o_saturated
);

    logic          w_push;
    logic          w_full;
    logic          w_q_valid;
    logic          w_pop;
    tgi_pkg::t_cmd w_cmd_in;
    tgi_pkg::t_cmd w_cmd_out;

    // coordinate scaling and command classification
    tgi_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .o_push           (w_push),
        .o_cmd            (w_cmd_in),
        .i_full           (w_full)
    );

    // command queue between front and back
    tgi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out),
        .i_pop   (w_pop)
    );

    // sample storage, gather and cubic evaluation
    tgi_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_cmd_out),
        .o_q_pop       (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_field_value (o_field_value),
        .o_saturated   (o_saturated)
    );

endmodule

// File: sv/tgi_fifo.sv
`include "tricubic_grid_interpolator_macros.svh"

module tgi_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgi_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output tgi_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    tgi_pkg::t_cmd                r_q [tgi_pkg::Q_DEPTH];
    logic [tgi_pkg::Q_AW-1:0]     r_wr;
    logic [tgi_pkg::Q_AW-1:0]     r_rd;
    logic [tgi_pkg::Q_AW:0]       r_count;

    assign o_full  = (r_count == (tgi_pkg::Q_AW+1)'(tgi_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_q[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (tgi_pkg::Q_AW+1)'(i_push) - (tgi_pkg::Q_AW+1)'(i_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_cmd;
    end

    `TGI_ASSERT_IMP(a_fifo_no_overflow, i_push, !o_full || i_pop, "queue push while full")
    `TGI_ASSERT_IMP(a_fifo_no_underflow, i_pop, o_valid, "queue pop while empty")

endmodule

// File: sv/tgi_front.sv
module tgi_front #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_opcode,
    input  logic [14:0]   i_sample_address,
    input  logic [31:0]   i_sample_value,
    input  logic [31:0]   i_pos_x,
    input  logic [31:0]   i_pos_y,
    input  logic [31:0]   i_pos_z,
    output logic          o_push,
    output tgi_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    tgi_pkg::t_front_state        r_state, n_state;
    logic [31:0]                  r_start [3];
    logic [31:0]                  r_inv [3];
    logic [31:0]                  r_pos [3];
    logic [1:0]                   r_ax;
    logic [64:0]                  r_prod;
    logic                         r_dneg;
    logic [tgi_pkg::OFF_W-1:0]    r_off [3];
    logic [tgi_pkg::U_W-1:0]      r_u [3];
    logic                         r_clip;

    logic                         w_acc;
    logic [32:0]                  w_d;
    logic [32:0]                  w_dmag;
    logic [64:0]                  w_rsum;
    logic [48:0]                  w_m;
    logic                         w_mclip;
    logic [31:0]                  w_mc;
    logic [tgi_pkg::U_W-1:0]      w_t;
    logic [14:0]                  w_idx;
    logic [8:0]                   w_size;
    logic [tgi_pkg::OFF_W-1:0]    w_off;
    logic [tgi_pkg::U_W-1:0]      w_u;

    assign o_in_stall = (r_state != tgi_pkg::F_IDLE) || i_full;
    assign w_acc      = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_start[k] <= '0;
                r_inv[k]   <= 32'h0001_0000;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tgi_pkg::CFG_START_X: r_start[0] <= i_cfg_data;
                tgi_pkg::CFG_START_Y: r_start[1] <= i_cfg_data;
                tgi_pkg::CFG_START_Z: r_start[2] <= i_cfg_data;
                tgi_pkg::CFG_INV_X:   r_inv[0]   <= i_cfg_data;
                tgi_pkg::CFG_INV_Y:   r_inv[1]   <= i_cfg_data;
                tgi_pkg::CFG_INV_Z:   r_inv[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offset from the grid origin and its magnitude
    assign w_d    = {r_pos[r_ax][31], r_pos[r_ax]} - {r_start[r_ax][31], r_start[r_ax]};
    assign w_dmag = w_d[32] ? (~w_d + 33'd1) : w_d;

    // round the scaled magnitude, clip, find the window start
    assign w_rsum = r_prod + 65'h8000;
    assign w_m    = w_rsum[64:16];

    always_comb begin
        unique case (r_ax)
            2'd0:    w_size = 9'(GRID_X);
            2'd1:    w_size = 9'(GRID_Y);
            default: w_size = 9'(GRID_Z);
        endcase
        if (r_dneg) begin
            w_mclip = (w_m > 49'h0_8000_0000);
            w_mc    = w_mclip ? 32'h8000_0000 : w_m[31:0];
            w_t     = tgi_pkg::U_W'(0) - {2'b00, w_mc};
            w_idx   = '0;
        end else begin
            w_mclip = (w_m > 49'h0_7FFF_FFFF);
            w_mc    = w_mclip ? 32'h7FFF_FFFF : w_m[31:0];
            w_t     = {2'b00, w_mc};
            w_idx   = w_mc[30:16];
        end
        w_off = '0;
        if (w_idx > 15'd1) begin
            if (16'(w_idx) > 16'(w_size) - 16'd3) w_off = tgi_pkg::OFF_W'(w_size - 9'd4);
            else                                   w_off = tgi_pkg::OFF_W'(w_idx - 15'd1);
        end
        w_u = w_t - tgi_pkg::U_W'({9'(w_off) + 9'd1, 16'h0000});
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tgi_pkg::F_IDLE;
        else          r_state <= n_state;
    end

    // next state and queue push
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            tgi_pkg::F_IDLE: begin
                o_cmd.opcode = tgi_pkg::OP_WRITE;
                o_cmd.addr   = i_sample_address;
                o_cmd.value  = i_sample_value;
                if (w_acc) begin
                    if (i_opcode == tgi_pkg::OP_WRITE) o_push  = 1'b1;
                    else                               n_state = tgi_pkg::F_MUL;
                end
            end
            tgi_pkg::F_MUL: n_state = tgi_pkg::F_RND;
            tgi_pkg::F_RND: n_state = (r_ax == 2'd2) ? tgi_pkg::F_PUSH : tgi_pkg::F_MUL;
            tgi_pkg::F_PUSH: begin
                o_cmd.opcode = tgi_pkg::OP_QUERY;
                o_cmd.ox     = r_off[0];
                o_cmd.oy     = r_off[1];
                o_cmd.oz     = r_off[2];
                o_cmd.ux     = r_u[0];
                o_cmd.uy     = r_u[1];
                o_cmd.uz     = r_u[2];
                o_cmd.clip   = r_clip;
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = tgi_pkg::F_IDLE;
                end
            end
            default: n_state = tgi_pkg::F_IDLE;
        endcase
    end

    // axis sequencing: one multiply and one round per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax   <= '0;
            r_clip <= 1'b0;
        end else begin
            if (r_state == tgi_pkg::F_IDLE && w_acc && i_opcode == tgi_pkg::OP_QUERY) begin
                r_ax   <= '0;
                r_clip <= 1'b0;
            end else if (r_state == tgi_pkg::F_RND) begin
                r_ax   <= r_ax + 2'd1;
                r_clip <= r_clip | w_mclip;
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        if (r_state == tgi_pkg::F_IDLE && w_acc) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
        end
        if (r_state == tgi_pkg::F_MUL) begin
            r_prod <= 65'(w_dmag) * 65'(r_inv[r_ax]);
            r_dneg <= w_d[32];
        end
        if (r_state == tgi_pkg::F_RND) begin
            r_off[r_ax] <= w_off;
            r_u[r_ax]   <= w_u;
        end
    end

endmodule

// File: sv/tgi_cubic.sv
`include "tricubic_grid_interpolator_macros.svh"

module tgi_cubic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgi_pkg::t_cubic_req i_req,
    output tgi_pkg::t_cubic_rsp o_rsp
);

    localparam int HW = tgi_pkg::H_W;

    tgi_pkg::t_cubic_state     r_state, n_state;
    logic [1:0]                r_step;
    logic [HW-1:0]             r_b;
    logic [HW-1:0]             r_c;
    logic [HW-1:0]             r_p1;
    logic [59:0]               r_mag;
    logic                      r_sgn;
    logic [31:0]               r_umag;
    logic                      r_uneg;
    logic [61:0]               r_pp;
    logic [91:0]               r_prod;
    logic [HW-1:0]             r_h;
    logic                      r_clip;
    logic                      r_done;
    logic [tgi_pkg::P_W-1:0]   r_r;

    logic signed [HW-1:0]      w_p [4];
    logic signed [HW-1:0]      w_a, w_bc, w_cc, w_dp;
    logic [HW-1:0]             w_amag;
    logic [tgi_pkg::U_W-1:0]   w_umag;
    logic [61:0]               w_hi;
    logic [91:0]               w_rs;
    logic [75:0]               w_rm;
    logic                      w_pclip;
    logic [HW-1:0]             w_mc;
    logic signed [HW-1:0]      w_sv;
    logic signed [HW:0]        w_sum;
    logic                      w_sclip;
    logic signed [HW-1:0]      w_hc;
    logic [HW-1:0]             w_hcmag;
    logic [HW-1:0]             w_hmag;
    logic [HW-1:0]             w_half;
    logic signed [HW:0]        w_res;
    logic                      w_fclip;
    logic [tgi_pkg::P_W-1:0]   w_resc;

    assign o_rsp.done = r_done;
    assign o_rsp.r    = r_r;
    assign o_rsp.clip = r_clip;

    // coefficients from the four points
    always_comb begin
        for (int k = 0; k < 4; k++) w_p[k] = HW'($signed(i_req.p[k]));
        w_dp   = w_p[1] - w_p[2];
        w_a    = (w_dp <<< 1) + w_dp + w_p[3] - w_p[0];
        w_bc   = (w_p[0] <<< 1) - ((w_p[1] <<< 2) + w_p[1]) + (w_p[2] <<< 2) - w_p[3];
        w_cc   = w_p[2] - w_p[0];
        w_amag = w_a[HW-1] ? HW'(-w_a) : HW'(w_a);
        w_umag = i_req.u[tgi_pkg::U_W-1] ? (~i_req.u + 1'b1) : i_req.u;
    end

    // upper partial product
    assign w_hi = 62'(r_mag[59:30]) * 62'(r_umag);

    // round the product, clip, apply sign, add the next coefficient
    always_comb begin
        w_rs    = r_prod + 92'h8000;
        w_rm    = w_rs[91:16];
        w_pclip = (w_rm > 76'(tgi_pkg::ACC_LIM));
        w_mc    = w_pclip ? tgi_pkg::ACC_LIM : w_rm[HW-1:0];
        w_sv    = (r_sgn ^ r_uneg) ? -$signed(w_mc) : $signed(w_mc);
        w_sum   = (HW+1)'(w_sv) + (HW+1)'($signed((r_step == 2'd0) ? r_b : r_c));
        w_sclip = 1'b0;
        if (w_sum > $signed((HW+1)'(tgi_pkg::ACC_LIM))) begin
            w_hc    = $signed(tgi_pkg::ACC_LIM);
            w_sclip = 1'b1;
        end else if (w_sum < -$signed((HW+1)'(tgi_pkg::ACC_LIM))) begin
            w_hc    = -$signed(tgi_pkg::ACC_LIM);
            w_sclip = 1'b1;
        end else begin
            w_hc = HW'(w_sum);
        end
        w_hcmag = w_hc[HW-1] ? HW'(-w_hc) : HW'(w_hc);
    end

    // halve with rounding and add the center point
    always_comb begin
        w_hmag  = r_h[HW-1] ? (~r_h + 1'b1) : r_h;
        w_half  = (w_hmag + HW'(1)) >> 1;
        w_res   = (HW+1)'($signed(r_p1))
                + (r_h[HW-1] ? -(HW+1)'($signed(w_half)) : (HW+1)'($signed(w_half)));
        w_fclip = 1'b0;
        if (w_res > $signed((HW+1)'(tgi_pkg::STAGE_LIM))) begin
            w_resc  = tgi_pkg::STAGE_LIM;
            w_fclip = 1'b1;
        end else if (w_res < -$signed((HW+1)'(tgi_pkg::STAGE_LIM))) begin
            w_resc  = tgi_pkg::P_W'(-$signed((HW+1)'(tgi_pkg::STAGE_LIM)));
            w_fclip = 1'b1;
        end else begin
            w_resc = tgi_pkg::P_W'(w_res);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tgi_pkg::C_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tgi_pkg::C_IDLE: if (i_req.start) n_state = tgi_pkg::C_MLO;
            tgi_pkg::C_MLO:  n_state = tgi_pkg::C_MHI;
            tgi_pkg::C_MHI:  n_state = tgi_pkg::C_ACC;
            tgi_pkg::C_ACC:  n_state = (r_step == 2'd2) ? tgi_pkg::C_FIN : tgi_pkg::C_MLO;
            tgi_pkg::C_FIN:  n_state = tgi_pkg::C_IDLE;
            default:         n_state = tgi_pkg::C_IDLE;
        endcase
    end

    // control: step count, clip flag, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_clip <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == tgi_pkg::C_FIN);
            if (r_state == tgi_pkg::C_IDLE && i_req.start) begin
                r_step <= '0;
                r_clip <= 1'b0;
            end else if (r_state == tgi_pkg::C_ACC) begin
                r_step <= r_step + 2'd1;
                r_clip <= r_clip | w_pclip | ((r_step != 2'd2) & w_sclip);
            end else if (r_state == tgi_pkg::C_FIN) begin
                r_clip <= r_clip | w_fclip;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tgi_pkg::C_IDLE: begin
                if (i_req.start) begin
                    r_b    <= w_bc;
                    r_c    <= w_cc;
                    r_p1   <= w_p[1];
                    r_mag  <= w_amag[59:0];
                    r_sgn  <= w_a[HW-1];
                    r_umag <= w_umag[31:0];
                    r_uneg <= i_req.u[tgi_pkg::U_W-1];
                end
            end
            tgi_pkg::C_MLO: r_pp   <= 62'(r_mag[29:0]) * 62'(r_umag);
            tgi_pkg::C_MHI: r_prod <= {w_hi, 30'd0} + 92'(r_pp);
            tgi_pkg::C_ACC: begin
                if (r_step == 2'd2) begin
                    r_h <= w_sv;
                end else begin
                    r_mag <= w_hcmag[59:0];
                    r_sgn <= w_hc[HW-1];
                end
            end
            tgi_pkg::C_FIN: r_r <= w_resc;
            default: ;
        endcase
    end

    `TGI_ASSERT_IMP(a_cubic_start_idle, i_req.start, r_state == tgi_pkg::C_IDLE,
        "cubic start while busy")

endmodule

// File: sv/tgi_back.sv
`include "tricubic_grid_interpolator_macros.svh"

module tgi_back #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tgi_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [31:0]   o_field_value,
    output logic          o_saturated
);

    localparam int GRID_SIZE = GRID_X * GRID_Y * GRID_Z;
    localparam int MEM_DEPTH = (GRID_SIZE < 32768) ? GRID_SIZE : 32768;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int GYZ       = GRID_Y * GRID_Z;
    localparam int PW        = tgi_pkg::P_W;

    tgi_pkg::t_back_state       r_state, n_state;
    tgi_pkg::t_level            r_lvl;
    logic [1:0]                 r_i, r_j;
    logic [2:0]                 r_k;
    logic                       r_cap_v;
    logic [1:0]                 r_cap_k;
    logic [31:0]                r_rdata;
    logic [31:0]                r_mem [MEM_DEPTH];
    logic [PW-1:0]              r_pz [4];
    logic [PW-1:0]              r_vy [4];
    logic [PW-1:0]              r_vx [4];
    logic [tgi_pkg::OFF_W-1:0]  r_ox, r_oy, r_oz;
    logic [tgi_pkg::U_W-1:0]    r_ux, r_uy, r_uz;
    logic                       r_flag;
    logic                       r_out_valid;
    logic [31:0]                r_field;
    logic                       r_sat;

    tgi_pkg::t_cubic_req        w_req;
    tgi_pkg::t_cubic_rsp        w_rsp;
    logic [31:0]                w_raddr;
    logic                       w_wr;
    logic                       w_load;
    logic [PW-1:0]              w_fmag;
    logic [41:0]                w_fr;
    logic                       w_fclip;
    logic [31:0]                w_fres;

    assign o_out_valid   = r_out_valid;
    assign o_field_value = r_field;
    assign o_saturated   = r_sat;

    // shared cubic unit
    tgi_cubic u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // linear address of the current neighbour
    assign w_raddr = (32'(r_ox) + 32'(r_i)) * 32'(GYZ)
                   + (32'(r_oy) + 32'(r_j)) * 32'(GRID_Z)
                   + 32'(r_oz) + 32'(r_k[1:0]);

    assign w_wr = o_q_pop && (i_q_cmd.opcode == tgi_pkg::OP_WRITE)
               && (32'(i_q_cmd.addr) < 32'(GRID_SIZE));

    // sample memory
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[i_q_cmd.addr[AW-1:0]] <= i_q_cmd.value;
        if (r_state == tgi_pkg::B_READ && !r_k[2]) r_rdata <= r_mem[w_raddr[AW-1:0]];
    end

    // cubic operand select by level
    always_comb begin
        w_req.start = (r_state == tgi_pkg::B_GO);
        unique case (r_lvl)
            tgi_pkg::LV_Z: begin
                for (int k = 0; k < 4; k++) w_req.p[k] = r_pz[k];
                w_req.u = r_uz;
            end
            tgi_pkg::LV_Y: begin
                for (int k = 0; k < 4; k++) w_req.p[k] = r_vy[k];
                w_req.u = r_uy;
            end
            default: begin
                for (int k = 0; k < 4; k++) w_req.p[k] = r_vx[k];
                w_req.u = r_ux;
            end
        endcase
    end

    // final rounding to an integer
    always_comb begin
        w_fmag = w_rsp.r[PW-1] ? (~w_rsp.r + 1'b1) : w_rsp.r;
        w_fr   = 42'((58'(w_fmag) + 58'h8000) >> 16);
        if (w_rsp.r[PW-1]) begin
            w_fclip = (w_fr > 42'h0_8000_0000);
            w_fres  = 32'd0 - (w_fclip ? 32'h8000_0000 : w_fr[31:0]);
        end else begin
            w_fclip = (w_fr > 42'h0_7FFF_FFFF);
            w_fres  = w_fclip ? 32'h7FFF_FFFF : w_fr[31:0];
        end
    end

    assign w_load = (r_state == tgi_pkg::B_FIN) && (!r_out_valid || !i_out_stall);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tgi_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // next state and queue pop
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            tgi_pkg::B_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && i_q_cmd.opcode == tgi_pkg::OP_QUERY) n_state = tgi_pkg::B_READ;
            end
            tgi_pkg::B_READ: if (r_k[2]) n_state = tgi_pkg::B_GO;
            tgi_pkg::B_GO:   n_state = tgi_pkg::B_WAIT;
            tgi_pkg::B_WAIT: begin
                if (w_rsp.done) begin
                    unique case (r_lvl)
                        tgi_pkg::LV_Z: n_state = (r_j == 2'd3) ? tgi_pkg::B_GO : tgi_pkg::B_READ;
                        tgi_pkg::LV_Y: n_state = (r_i == 2'd3) ? tgi_pkg::B_GO : tgi_pkg::B_READ;
                        default:       n_state = tgi_pkg::B_FIN;
                    endcase
                end
            end
            tgi_pkg::B_FIN:  if (w_load) n_state = tgi_pkg::B_IDLE;
            default:         n_state = tgi_pkg::B_IDLE;
        endcase
    end

    // gather counters, level, flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl       <= tgi_pkg::LV_Z;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_cap_v     <= 1'b0;
            r_cap_k     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_v <= (r_state == tgi_pkg::B_READ) && !r_k[2];
            r_cap_k <= r_k[1:0];
            if (r_state == tgi_pkg::B_IDLE && i_q_valid
                    && i_q_cmd.opcode == tgi_pkg::OP_QUERY) begin
                r_lvl  <= tgi_pkg::LV_Z;
                r_i    <= '0;
                r_j    <= '0;
                r_k    <= '0;
                r_flag <= i_q_cmd.clip;
            end
            if (r_state == tgi_pkg::B_READ) r_k <= r_k + 3'd1;
            if (r_state == tgi_pkg::B_WAIT && w_rsp.done) begin
                r_flag <= r_flag | w_rsp.clip;
                r_k    <= '0;
                unique case (r_lvl)
                    tgi_pkg::LV_Z: begin
                        if (r_j == 2'd3) r_lvl <= tgi_pkg::LV_Y;
                        else             r_j   <= r_j + 2'd1;
                    end
                    tgi_pkg::LV_Y: begin
                        r_j <= '0;
                        if (r_i == 2'd3) r_lvl <= tgi_pkg::LV_X;
                        else begin
                            r_i   <= r_i + 2'd1;
                            r_lvl <= tgi_pkg::LV_Z;
                        end
                    end
                    default: ;
                endcase
            end
            if (w_load)                           r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == tgi_pkg::B_IDLE && i_q_valid) begin
            r_ox <= i_q_cmd.ox;
            r_oy <= i_q_cmd.oy;
            r_oz <= i_q_cmd.oz;
            r_ux <= i_q_cmd.ux;
            r_uy <= i_q_cmd.uy;
            r_uz <= i_q_cmd.uz;
        end
        if (r_cap_v) r_pz[r_cap_k] <= {{9{r_rdata[31]}}, r_rdata, 16'h0000};
        if (r_state == tgi_pkg::B_WAIT && w_rsp.done) begin
            if (r_lvl == tgi_pkg::LV_Z) r_vy[r_j] <= w_rsp.r;
            if (r_lvl == tgi_pkg::LV_Y) r_vx[r_i] <= w_rsp.r;
        end
        if (w_load) begin
            r_field <= w_fres;
            r_sat   <= r_flag | w_fclip;
        end
    end

    `TGI_ASSERT_IMP(a_back_done_waiting, w_rsp.done, r_state == tgi_pkg::B_WAIT,
        "cubic result arrived while not waiting")
    `TGI_ASSERT_NXT(a_back_result_held, r_out_valid && i_out_stall, r_out_valid,
        "pending result dropped under stall")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NX = 32;
    localparam int NY = 32;
    localparam int NZ = 32;
    localparam int NCELLS = NX * NY * NZ;
    localparam longint ONE = 65536;
    localparam int DRAIN = 400;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } t_field_word;

    // predicts interpolated field words and checks them in order
    class tricubic_predictor;
        logic [31:0]     samples [NCELLS];
        longint          origin [3];
        longint unsigned inv_step [3];
        t_field_word     pending_fields [$];
        int              mismatches;
        int              n_writes;
        int              n_queries;

        function new();
            for (int k = 0; k < 3; k++) begin
                origin[k] = 0;
                inv_step[k] = 65536;
            end
            mismatches = 0;
            n_writes = 0;
            n_queries = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            if (idx <= tgi_pkg::CFG_START_Z)
                origin[idx] = longint'($signed(data));
            else if (idx <= tgi_pkg::CFG_INV_Z)
                inv_step[idx - tgi_pkg::CFG_INV_X] = longint'({32'b0, data});
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint clip(longint v, longint lim, inout bit f);
            if (v > lim) begin
                f = 1;
                return lim;
            end
            if (v < -lim) begin
                f = 1;
                return -lim;
            end
            return v;
        endfunction

        // q.16 value times q16.16 coordinate, rounded and clipped
        function longint mul_coord(longint a, longint x, inout bit f);
            bit neg;
            logic [127:0] prod;
            logic [127:0] r;
            neg = (a < 0) != (x < 0);
            prod = {64'b0, mag(a)} * {64'b0, mag(x)};
            r = (prod + 128'h8000) >> 16;
            if (r > {67'b0, tgi_pkg::ACC_LIM}) begin
                r = {67'b0, tgi_pkg::ACC_LIM};
                f = 1;
            end
            return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
        endfunction

        function longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                     longint u, inout bit f);
            longint a, b, c, h, half, lim;
            lim = longint'(tgi_pkg::ACC_LIM);
            a = 3 * (p1 - p2) + p3 - p0;
            b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c = p2 - p0;
            h = clip(mul_coord(a, u, f) + b, lim, f);
            h = clip(mul_coord(h, u, f) + c, lim, f);
            h = mul_coord(h, u, f);
            half = longint'((mag(h) + 1) >> 1);
            if (h < 0)
                half = -half;
            return clip(p1 + half, longint'(tgi_pkg::STAGE_LIM), f);
        endfunction

        // grid scaling of one coordinate: window start and local coordinate
        function void scale_axis(logic [31:0] pos, int k, int size,
                                 output int off, output longint u, inout bit f);
            longint d, t, idx;
            longint unsigned m;
            d = longint'($signed(pos)) - origin[k];
            m = (mag(d) * inv_step[k] + 64'h8000) >> 16;
            if (d < 0) begin
                if (m > 64'h8000_0000) begin
                    m = 64'h8000_0000;
                    f = 1;
                end
                t = -longint'(m);
                idx = -longint'(m >> 16);
            end else begin
                if (m > 64'h7FFF_FFFF) begin
                    m = 64'h7FFF_FFFF;
                    f = 1;
                end
                t = longint'(m);
                idx = longint'(m >> 16);
            end
            off = 0;
            if (idx > 1) begin
                off = int'(idx - 1);
                if (idx > size - 3)
                    off = size - 4;
            end
            u = t - longint'(off) * ONE - ONE;
        endfunction

        function void note_word(logic op, logic [14:0] addr, logic [31:0] val,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            bit f;
            int ox, oy, oz, a;
            longint ux, uy, uz, r;
            longint vx [4];
            longint vy [4];
            longint vz [4];
            longint unsigned mr;
            t_field_word w;
            if (op == tgi_pkg::OP_WRITE) begin
                if (int'(addr) < NCELLS)
                    samples[addr] = val;
                n_writes++;
                return;
            end
            f = 0;
            scale_axis(px, 0, NX, ox, ux, f);
            scale_axis(py, 1, NY, oy, uy, f);
            scale_axis(pz, 2, NZ, oz, uz, f);
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    for (int k = 0; k < 4; k++) begin
                        a = (i + ox) * NY * NZ + (j + oy) * NZ + (k + oz);
                        vz[k] = longint'($signed(samples[a])) * ONE;
                    end
                    vy[j] = catmull_rom(vz[0], vz[1], vz[2], vz[3], uz, f);
                end
                vx[i] = catmull_rom(vy[0], vy[1], vy[2], vy[3], uy, f);
            end
            r = catmull_rom(vx[0], vx[1], vx[2], vx[3], ux, f);
            mr = (mag(r) + 64'h8000) >> 16;
            if (r < 0) begin
                if (mr > 64'h8000_0000) begin
                    mr = 64'h8000_0000;
                    f = 1;
                end
                w.value = 32'(-longint'(mr));
            end else begin
                if (mr > 64'h7FFF_FFFF) begin
                    mr = 64'h7FFF_FFFF;
                    f = 1;
                end
                w.value = 32'(mr);
            end
            w.sat = f;
            pending_fields.push_back(w);
            n_queries++;
        endfunction

        function void check_word(logic [31:0] value, logic sat);
            t_field_word w;
            if (pending_fields.size() == 0) begin
                $display("%0t: unexpected result word value %h sat %b", $time, value, sat);
                mismatches++;
                return;
            end
            w = pending_fields.pop_front();
            if (value !== w.value) begin
                $display("%0t: field_value expected %h actual %h", $time, w.value, value);
                mismatches++;
            end
            if (sat !== w.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, w.sat, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [14:0] i_sample_address;
    logic [31:0] i_sample_value;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_field_value;
    logic        o_saturated;

    tricubic_predictor fields = new();
    bit gaps_on = 1;
    int stall_left = 0;
    int settings = 0;

    tricubic_grid_interpolator dut (.*);

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // result side: check accepted words, stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                fields.check_word(o_field_value, o_saturated);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic send_word(logic op, logic [14:0] addr, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        i_in_valid <= 1;
        i_opcode <= op;
        i_sample_address <= addr;
        i_sample_value <= val;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (o_in_stall);
        fields.note_word(op, addr, val, px, py, pz);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_sample(int addr, logic [31:0] val);
        send_word(tgi_pkg::OP_WRITE, 15'(addr), val, $urandom, $urandom, $urandom);
    endtask

    task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_word(tgi_pkg::OP_QUERY, 15'($urandom), $urandom, px, py, pz);
    endtask

    // wait for every result, then for the block to settle
    task automatic drain();
        i_in_valid <= 0;
        while (fields.pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
        logic [31:0] vals [6];
        vals = '{sx, sy, sz, ix, iy, iz};
        drain();
        for (int r = 0; r < 6; r++) begin
            i_cfg_we <= 1;
            i_cfg_index <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            fields.set_reg(3'(r), vals[r]);
        end
        i_cfg_we <= 0;
        settings++;
    endtask

    function automatic logic [31:0] mixed_sample();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
    endfunction

    // mostly positions around the grid, some anywhere
    function automatic logic [31:0] grid_pos(int k);
        longint g, p;
        if (fields.inv_step[k] == 0 || $urandom_range(0, 4) == 0)
            return $urandom;
        g = longint'($urandom_range(0, 38 << 16)) - (3 << 16);
        p = fields.origin[k] + (g * ONE) / longint'(fields.inv_step[k]);
        if (p > 64'sh7FFF_FFFF)
            p = 64'sh7FFF_FFFF;
        if (p < -64'sh8000_0000)
            p = -64'sh8000_0000;
        return 32'(p);
    endfunction

    task automatic random_words(int count);
        repeat (count) begin
            if ($urandom_range(0, 9) < 4)
                write_sample($urandom_range(0, NCELLS - 1), mixed_sample());
            else
                query(grid_pos(0), grid_pos(1), grid_pos(2));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_opcode = 0;
        i_sample_address = 0;
        i_sample_value = 0;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // every cell gets a value before any query reads it
        for (int a = 0; a < NCELLS; a++)
            write_sample(a, 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000));

        // directed: extreme samples, edges, extrapolation, clipped positions
        set_grid(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        write_sample(0, 32'h7FFF_FFFF);
        write_sample(1, 32'h8000_0000);
        write_sample(NCELLS - 1, 32'h8000_0000);
        write_sample(NCELLS - 2, 32'h7FFF_FFFF);
        query(0, 0, 0);
        query(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        query(32'h0001_8000, 32'h0002_8000, 32'h0003_C000);
        query(32'h000F_8000, 32'h0010_4000, 32'h0011_0000);
        query(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        query(32'hFFFA_8000, 32'h0000_8000, 32'h0000_8000);
        query(32'h001F_0000, 32'h001F_0000, 32'h001F_0000);
        query(32'h0028_0000, 32'h001E_8000, 32'h0028_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query(32'h7FFF_FFFF, 32'h8000_0000, 0);
        write_sample(NCELLS / 2, 32'h0000_1000);
        query(32'h0010_0000, 0, 0);

        // random phases across register settings
        random_words(150);
        set_grid(32'h0005_0000, 32'hFFFC_C000, 32'h0064_8000,
                 32'h0002_0000, 32'h0000_8000, 32'h0001_8000);
        random_words(140);
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1, 32'h0001_0000);
        query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000);
        random_words(120);
        set_grid($urandom_range(0, 4 << 16), $urandom_range(0, 4 << 16),
                 $urandom_range(0, 4 << 16), 0, $urandom_range(32768, 131072),
                 $urandom_range(32768, 131072));
        random_words(120);
        set_grid(32'($signed($urandom_range(0, 32 << 16)) - (16 << 16)),
                 32'($signed($urandom_range(0, 32 << 16)) - (16 << 16)),
                 32'($signed($urandom_range(0, 32 << 16)) - (16 << 16)),
                 $urandom_range(49152, 98304), $urandom_range(49152, 98304),
                 $urandom_range(49152, 98304));
        random_words(150);

        // last stretch at full rate on both sides
        set_grid(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        gaps_on = 0;
        random_words(150);
        drain();

        $display("run covered %0d sample writes and %0d queries under %0d grid settings",
                 fields.n_writes, fields.n_queries, settings);
        if (fields.mismatches == 0 && fields.pending_fields.size() == 0)
            $display("PASS tricubic_grid_interpolator");
        else
            $display("FAIL tricubic_grid_interpolator");
        $finish;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("FAIL tricubic_grid_interpolator");
        $finish;
    end

endmodule
